// File: rtl/core/vtiu_pkg.sv
`timescale 1ns / 1ps
// vtiu_pkg: shared types, command codes and timing constants for the
// video timing and interrupt unit. No dependencies.
package vtiu_pkg;

	// default frame geometry, used as the defaults of the top level parameters
	localparam int unsigned DOTS_PER_LINE_DEF   = 341;
	localparam int unsigned LINES_PER_FRAME_DEF = 262;

	localparam logic [8:0]  VBLANK_LINE         = 9'd225;
	localparam logic [8:0]  HBLANK_DOT          = 9'd274;
	localparam logic [8:0]  HBLANK_END_DOT      = 9'd1;
	localparam logic [8:0]  JOY_START_DOT       = 9'd76;
	localparam logic [10:0] JOY_WINDOW_DOTS     = 11'd1056;
	localparam logic [7:0]  CHIP_VERSION        = 8'h02;
	localparam logic [8:0]  COMPARE_RESET       = 9'h1FF;
	localparam logic [8:0]  VISIBLE_LINES_RESET = 9'd225;

	// timer irq modes, bits 5-4 of the interrupt enable register
	localparam logic [1:0] IRQ_MODE_OFF = 2'd0;
	localparam logic [1:0] IRQ_MODE_H   = 2'd1;
	localparam logic [1:0] IRQ_MODE_V   = 2'd2;
	localparam logic [1:0] IRQ_MODE_HV  = 2'd3;

	localparam logic [3:0] CMD_TICK       = 4'd0;
	localparam logic [3:0] CMD_WR_NMITIMEN = 4'd1;
	localparam logic [3:0] CMD_WR_HTIME_LO = 4'd2;
	localparam logic [3:0] CMD_WR_HTIME_HI = 4'd3;
	localparam logic [3:0] CMD_WR_VTIME_LO = 4'd4;
	localparam logic [3:0] CMD_WR_VTIME_HI = 4'd5;
	localparam logic [3:0] CMD_RD_RDNMI   = 4'd6;
	localparam logic [3:0] CMD_RD_TIMEUP  = 4'd7;
	localparam logic [3:0] CMD_RD_HVBJOY  = 4'd8;
	localparam logic [3:0] CMD_SOFT_RESET = 4'd9;

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] write_data;
	} vtiu_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       nmi_pulse;
		logic       hdma_line_event;
		logic       frame_start_event;
		logic       joypad_start_event;
	} vtiu_out_t;

endpackage

// File: rtl/core/video_timing_interrupt_unit_top.sv
`timescale 1ns / 1ps
// video_timing_interrupt_unit_top: top level of the video timing and interrupt unit.
// Depends on vtiu_pkg, vtiu_in_stage, vtiu_core and vtiu_out_stage.

// Takes one command word per clock (a dot tick, a register write, a status read or a
// soft reset) and returns exactly one result word for each, in order. A word is
// captured in the input register, then the state update and the result are worked
// out combinationally and land in the output register, so the unit sustains one
// word per clock while the output side keeps taking results. cfg_we writes
// visible_lines at once, and is meant to be used only while no words are in flight.
module video_timing_interrupt_unit_top #(
	parameter int unsigned DOTS_PER_LINE   = vtiu_pkg::DOTS_PER_LINE_DEF,
	parameter int unsigned LINES_PER_FRAME = vtiu_pkg::LINES_PER_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vtiu_pkg::vtiu_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vtiu_pkg::vtiu_out_t out_data,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata
);
	import vtiu_pkg::*;

	logic      item_valid;
	vtiu_in_t  item;
	logic      slot_free;
	logic      advance;
	vtiu_out_t result;

	assign advance = item_valid && slot_free;

	vtiu_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	vtiu_core #(
		.DOTS_PER_LINE   (DOTS_PER_LINE),
		.LINES_PER_FRAME (LINES_PER_FRAME)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item),
		.result    (result)
	);

	vtiu_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/core/vtiu_in_stage.sv
`timescale 1ns / 1ps
// vtiu_in_stage: input register for command words.
// Depends on vtiu_pkg.
module vtiu_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vtiu_pkg::vtiu_in_t in_data,
	input  logic              advance,
	output logic              item_valid,
	output vtiu_pkg::vtiu_in_t item
);
	import vtiu_pkg::*;

	logic     valid_s1;
	vtiu_in_t data_s1;

	// empty, or the held word moves on this cycle
	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

// File: rtl/core/vtiu_core.sv
`timescale 1ns / 1ps
// vtiu_core: dot/line counters, blank flags, nmi and timer irq logic,
// auto-joypad window and status reads. Depends on vtiu_pkg.
module vtiu_core #(
	parameter int unsigned DOTS_PER_LINE   = vtiu_pkg::DOTS_PER_LINE_DEF,
	parameter int unsigned LINES_PER_FRAME = vtiu_pkg::LINES_PER_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata,
	input  logic               step,
	input  vtiu_pkg::vtiu_in_t item,
	output vtiu_pkg::vtiu_out_t result
);
	import vtiu_pkg::*;

	localparam logic [9:0] DOTS_LIMIT  = 10'(DOTS_PER_LINE);
	localparam logic [9:0] LINES_LIMIT = 10'(LINES_PER_FRAME);

	logic [8:0]  visible_lines_q;
	logic [8:0]  dot_q, line_q;
	logic        vblank_q, hblank_q, nmi_latch_q, nmi_prev_q, irq_q;
	logic [7:0]  int_en_q;
	logic [8:0]  h_cmp_q, v_cmp_q;
	logic        joy_busy_q;
	logic [10:0] joy_left_q;
	logic        first_tick_q;

	logic [8:0]  dot_d, line_d;
	logic        vblank_d, hblank_d, nmi_latch_d, nmi_prev_d, irq_d;
	logic [7:0]  int_en_d;
	logic [8:0]  h_cmp_d, v_cmp_d;
	logic        joy_busy_d;
	logic [10:0] joy_left_d;
	logic        first_tick_d;
	vtiu_out_t   res;

	always_comb begin
		logic [9:0] dot_inc;
		logic [9:0] line_inc;
		logic       match;
		logic       src;
		logic       joy_start;

		dot_d        = dot_q;
		line_d       = line_q;
		vblank_d     = vblank_q;
		hblank_d     = hblank_q;
		nmi_latch_d  = nmi_latch_q;
		nmi_prev_d   = nmi_prev_q;
		irq_d        = irq_q;
		int_en_d     = int_en_q;
		h_cmp_d      = h_cmp_q;
		v_cmp_d      = v_cmp_q;
		joy_busy_d   = joy_busy_q;
		joy_left_d   = joy_left_q;
		first_tick_d = first_tick_q;
		res          = '0;
		dot_inc      = {1'b0, dot_q} + 10'd1;
		line_inc     = {1'b0, line_q} + 10'd1;
		match        = 1'b0;
		src          = 1'b0;
		joy_start    = 1'b0;

		case (item.command)
			CMD_TICK: begin
				if (first_tick_q) begin
					first_tick_d = 1'b0;
					if (line_q == '0) begin
						res.frame_start_event = 1'b1;
					end
				end
				if (dot_inc >= DOTS_LIMIT) begin
					dot_d = '0;
					line_d = (line_inc >= LINES_LIMIT) ? '0 : line_inc[8:0];
				end else begin
					dot_d = dot_inc[8:0];
				end

				if (dot_d == '0 && line_d == VBLANK_LINE) begin
					vblank_d    = 1'b1;
					nmi_latch_d = 1'b1;
				end
				if (dot_d == '0 && line_d == '0) begin
					vblank_d              = 1'b0;
					nmi_latch_d           = 1'b0;
					res.frame_start_event = 1'b1;
				end

				if (dot_d == HBLANK_DOT) begin
					hblank_d = 1'b1;
				end
				if (dot_d == HBLANK_END_DOT) begin
					hblank_d = 1'b0;
				end
				res.hdma_line_event = (dot_d == HBLANK_DOT) && (line_d < visible_lines_q);

				case (int_en_q[5:4])
					IRQ_MODE_H:  match = (dot_d == h_cmp_q);
					IRQ_MODE_V:  match = (line_d == v_cmp_q) && (dot_d == '0);
					IRQ_MODE_HV: match = (dot_d == h_cmp_q) && (line_d == v_cmp_q);
					default:     match = 1'b0;
				endcase
				if (match) begin
					irq_d = 1'b1;
				end

				src           = int_en_q[7] && nmi_latch_d;
				res.nmi_pulse = src && !nmi_prev_q;
				nmi_prev_d    = src;

				joy_start = (dot_d == JOY_START_DOT) && (line_d == VBLANK_LINE) &&
					int_en_q[0] && !joy_busy_q;
				if (joy_start) begin
					joy_busy_d             = 1'b1;
					joy_left_d             = JOY_WINDOW_DOTS;
					res.joypad_start_event = 1'b1;
				end
				// window counts down on the same dot it opens
				if (joy_busy_d) begin
					if (joy_left_d != '0) begin
						joy_left_d = joy_left_d - 11'd1;
					end
					if (joy_left_d == '0) begin
						joy_busy_d = 1'b0;
					end
				end
			end
			CMD_WR_NMITIMEN: begin
				int_en_d = item.write_data;
				if (item.write_data[5:4] == IRQ_MODE_OFF) begin
					irq_d = 1'b0;
				end
			end
			CMD_WR_HTIME_LO: h_cmp_d = {h_cmp_q[8], item.write_data};
			CMD_WR_HTIME_HI: h_cmp_d = {item.write_data[0], h_cmp_q[7:0]};
			CMD_WR_VTIME_LO: v_cmp_d = {v_cmp_q[8], item.write_data};
			CMD_WR_VTIME_HI: v_cmp_d = {item.write_data[0], v_cmp_q[7:0]};
			CMD_RD_RDNMI: begin
				res.read_data = {nmi_latch_q, 7'd0} | CHIP_VERSION;
				nmi_latch_d   = 1'b0;
			end
			CMD_RD_TIMEUP: begin
				res.read_data = {irq_q, 7'd0};
				irq_d         = 1'b0;
			end
			CMD_RD_HVBJOY: begin
				res.read_data = {vblank_q, hblank_q, 5'd0, joy_busy_q};
			end
			CMD_SOFT_RESET: begin
				int_en_d     = '0;
				irq_d        = 1'b0;
				dot_d        = '0;
				line_d       = '0;
				vblank_d     = 1'b0;
				hblank_d     = 1'b0;
				nmi_prev_d   = 1'b0;
				joy_busy_d   = 1'b0;
				joy_left_d   = '0;
				first_tick_d = 1'b1;
			end
			default: begin
			end
		endcase
		res.irq_level = irq_d;
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_lines_q <= VISIBLE_LINES_RESET;
		end else if (cfg_we) begin
			visible_lines_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q        <= '0;
			line_q       <= '0;
			vblank_q     <= 1'b0;
			hblank_q     <= 1'b0;
			nmi_latch_q  <= 1'b0;
			nmi_prev_q   <= 1'b0;
			irq_q        <= 1'b0;
			int_en_q     <= '0;
			h_cmp_q      <= COMPARE_RESET;
			v_cmp_q      <= COMPARE_RESET;
			joy_busy_q   <= 1'b0;
			joy_left_q   <= '0;
			first_tick_q <= 1'b1;
		end else if (step) begin
			dot_q        <= dot_d;
			line_q       <= line_d;
			vblank_q     <= vblank_d;
			hblank_q     <= hblank_d;
			nmi_latch_q  <= nmi_latch_d;
			nmi_prev_q   <= nmi_prev_d;
			irq_q        <= irq_d;
			int_en_q     <= int_en_d;
			h_cmp_q      <= h_cmp_d;
			v_cmp_q      <= v_cmp_d;
			joy_busy_q   <= joy_busy_d;
			joy_left_q   <= joy_left_d;
			first_tick_q <= first_tick_d;
		end
	end

`ifndef ASSERT_OFF
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, dot_q} < DOTS_LIMIT)
		else $error("dot counter out of range");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_q} < LINES_LIMIT)
		else $error("line counter out of range");

	a_joy_window: assert property (@(posedge clk) disable iff (!arst_n)
		joy_busy_q == (joy_left_q != '0))
		else $error("joypad busy flag disagrees with window count");

	a_soft_reset: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command == CMD_SOFT_RESET |=> first_tick_q && dot_q == '0 &&
		line_q == '0 && !irq_q)
		else $error("soft reset did not restart timing");
`endif

endmodule

// File: rtl/core/vtiu_out_stage.sv
`timescale 1ns / 1ps
// vtiu_out_stage: result register with valid/ready handshake.
// Depends on vtiu_pkg.
module vtiu_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  vtiu_pkg::vtiu_out_t result,
	output logic                slot_free,
	output logic                out_valid,
	input  logic                out_ready,
	output vtiu_pkg::vtiu_out_t out_data
);
	import vtiu_pkg::*;

	logic      valid_s2;
	vtiu_out_t data_s2;

	// register empty, or its word leaves this cycle
	assign slot_free = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (slot_free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= result;
		end
	end

endmodule
